>>> rtl/core/tcw_pkg.sv
// ============================================================================
// tcw_pkg
// Shared types and constants of the text console writer: default geometry,
// control character codes, command codes, port widths and sequencer types.
// ============================================================================
package tcw_pkg;

   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STEP = 4;

   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int CELL_W     = 16;
   localparam int ADDR_IN_W  = 11;
   localparam int COLUMN_W   = 7;
   localparam int ROW_W      = 5;
   localparam int LOCATION_W = 11;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TILDE     = 8'h7E;

   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_DONE
   } seq_state_type;

   // status of the cursor unit for the character being processed
   typedef struct packed {
      logic cell_write;
      logic scroll_needed;
   } cursor_status_type;

endpackage

>>> rtl/core/tcw_cell_store.sv
// ============================================================================
// tcw_cell_store
// Text cell memory: one write port, one read port with registered data.
// ============================================================================
module tcw_cell_store
   import tcw_pkg::*;
#(
   parameter int CELLS = DEF_COLUMNS * DEF_ROWS,
   parameter int AW    = $clog2(CELLS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/tcw_cursor.sv
// ============================================================================
// tcw_cursor
// Cursor unit: decodes one character, computes the next column, row, row
// base and tab phase, and the cell write it causes.
// ============================================================================
module tcw_cursor
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STEP = DEF_TAB_STEP,
   parameter int CELLS    = COLUMNS * ROWS,
   parameter int CW       = $clog2(COLUMNS),
   parameter int RW       = $clog2(ROWS),
   parameter int LW       = $clog2(CELLS + 1),
   parameter int AW       = $clog2(CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] char_code,
   input  logic [ATTR_W-1:0] attribute,
   output logic [CW-1:0]     column,
   output logic [RW-1:0]     row,
   output logic [LW-1:0]     location,
   output cursor_status_type status,
   output logic [AW-1:0]     wr_addr,
   output logic [CELL_W-1:0] wr_data
);

   localparam int CXW = $clog2(COLUMNS + TAB_STEP + 1);
   localparam int PW  = $clog2(TAB_STEP + 1);

   logic [CW-1:0]  column_ff,   column_in;
   logic [RW-1:0]  row_ff,      row_in;
   logic [LW-1:0]  row_base_ff, row_base_in;
   logic [PW-1:0]  phase_ff,    phase_in;

   logic [CXW-1:0]    col_x;
   logic [CXW-1:0]    col_next;
   logic              newline;
   logic              write;
   logic              write_back;
   logic              wrap;
   logic              row_adv;
   logic              scroll;
   logic [CHAR_W-1:0] wr_char;
   logic [LW-1:0]     loc;
   logic [LW-1:0]     wr_loc;

   always_comb begin
      col_x      = CXW'(column_ff);
      col_next   = col_x;
      phase_in   = phase_ff;
      newline    = 1'b0;
      write      = 1'b0;
      write_back = 1'b0;
      wr_char    = char_code;
      unique case (char_code)
         CHAR_NEWLINE: begin
            newline  = 1'b1;
            col_next = '0;
            phase_in = '0;
         end
         CHAR_RETURN: begin
            col_next = '0;
            phase_in = '0;
         end
         CHAR_BACKSPACE: begin
            if (column_ff != '0) begin
               col_next   = col_x - CXW'(1);
               write      = 1'b1;
               write_back = 1'b1;
               wr_char    = CHAR_BLANK;
               phase_in   = (phase_ff == '0) ? PW'(TAB_STEP - 1) : phase_ff - PW'(1);
            end
         end
         CHAR_TAB: begin
            col_next = col_x + CXW'(TAB_STEP) - CXW'(phase_ff);
            phase_in = '0;
         end
         default: begin
            if (char_code >= CHAR_BLANK && char_code <= CHAR_TILDE) begin
               write    = 1'b1;
               col_next = col_x + CXW'(1);
               phase_in = (phase_ff == PW'(TAB_STEP - 1)) ? '0 : phase_ff + PW'(1);
            end
         end
      endcase

      wrap = (col_next >= CXW'(COLUMNS));
      if (wrap) begin
         col_next = '0;
         phase_in = '0;
      end
      column_in = col_next[CW-1:0];

      row_adv     = newline | wrap;
      scroll      = row_adv && (row_ff == RW'(ROWS - 1));
      row_in      = row_ff;
      row_base_in = row_base_ff;
      if (row_adv && !scroll) begin
         row_in      = row_ff + RW'(1);
         row_base_in = row_base_ff + LW'(COLUMNS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= '0;
         row_ff      <= '0;
         row_base_ff <= '0;
         phase_ff    <= '0;
      end else if (step) begin
         column_ff   <= column_in;
         row_ff      <= row_in;
         row_base_ff <= row_base_in;
         phase_ff    <= phase_in;
      end
   end

   assign loc    = row_base_ff + LW'(column_ff);
   assign wr_loc = write_back ? loc - LW'(1) : loc;

   assign column               = column_ff;
   assign row                  = row_ff;
   assign location             = loc;
   assign status.cell_write    = write;
   assign status.scroll_needed = scroll;
   assign wr_addr              = wr_loc[AW-1:0];
   assign wr_data              = {attribute, wr_char};

endmodule

>>> rtl/core/tcw_sequencer.sv
// ============================================================================
// tcw_sequencer
// Control sequencer: takes transactions, runs the clearing pass and the
// scroll copy with one address counter, drives the cell store and builds
// the result.
// ============================================================================
module tcw_sequencer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS,
   parameter int CELLS   = COLUMNS * ROWS,
   parameter int CW      = $clog2(COLUMNS),
   parameter int RW      = $clog2(ROWS),
   parameter int LW      = $clog2(CELLS + 1),
   parameter int AW      = $clog2(CELLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [ADDR_IN_W-1:0]  req_cell_address,
   output logic                  put_step,
   output logic [CHAR_W-1:0]     char_code,
   input  cursor_status_type     cursor_status,
   input  logic [CW-1:0]         cursor_column,
   input  logic [RW-1:0]         cursor_row,
   input  logic [LW-1:0]         cursor_location,
   input  logic [AW-1:0]         cursor_wr_addr,
   input  logic [CELL_W-1:0]     cursor_wr_data,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [CELL_W-1:0]     mem_wr_data,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [CELL_W-1:0]     mem_rd_data,
   output logic                  rsp_valid,
   output logic [COLUMN_W-1:0]   rsp_cursor_column,
   output logic [ROW_W-1:0]      rsp_cursor_row,
   output logic [LOCATION_W-1:0] rsp_cursor_location,
   output logic                  rsp_scrolled,
   output logic [CELL_W-1:0]     rsp_cell_value
);

   localparam int IW = $clog2(CELLS + 1);
   localparam int SW = $clog2(CELLS + COLUMNS + 1);
   localparam int XW = ADDR_IN_W + SW;

   seq_state_type state_ff, state_in;

   logic [IW-1:0]        idx_ff, idx_in;
   logic                 cmd_ff;
   logic [CHAR_W-1:0]    char_ff;
   logic [ADDR_IN_W-1:0] addr_ff;
   logic                 scrolled_ff, scrolled_in;

   logic                  rsp_valid_ff;
   logic [COLUMN_W-1:0]   rsp_column_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic [LOCATION_W-1:0] rsp_location_ff;
   logic                  rsp_scrolled_ff;
   logic [CELL_W-1:0]     rsp_cell_ff;

   logic          accept;
   logic          in_range;
   logic [SW-1:0] copy_src;
   logic [IW-1:0] copy_dst;

   assign busy     = !(state_ff == ST_IDLE || state_ff == ST_DONE);
   assign accept   = start && !busy;
   assign in_range = (XW'(addr_ff) < XW'(CELLS));
   assign copy_src = SW'(idx_ff) + SW'(COLUMNS);
   assign copy_dst = idx_ff - IW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (idx_ff == IW'(CELLS - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (start) state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd_ff == CMD_PUT && cursor_status.scroll_needed) begin
               state_in = ST_SCROLL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: if (idx_ff == IW'(CELLS)) state_in = ST_DONE;
         ST_DONE:   state_in = start ? ST_EXEC : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      put_step    = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = cursor_wr_addr;
      mem_wr_data = cursor_wr_data;
      mem_rd_addr = AW'(addr_ff);
      idx_in      = idx_ff;
      scrolled_in = scrolled_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = idx_ff[AW-1:0];
            mem_wr_data = '0;
            idx_in      = idx_ff + IW'(1);
         end
         ST_EXEC: begin
            put_step    = (cmd_ff == CMD_PUT);
            mem_wr_en   = (cmd_ff == CMD_PUT) && cursor_status.cell_write;
            scrolled_in = (cmd_ff == CMD_PUT) && cursor_status.scroll_needed;
            idx_in      = '0;
         end
         ST_SCROLL: begin
            // read one row ahead, write the previous read one cell behind
            mem_rd_addr = copy_src[AW-1:0];
            mem_wr_en   = (idx_ff != '0);
            mem_wr_addr = copy_dst[AW-1:0];
            mem_wr_data = (idx_ff <= IW'(CELLS - COLUMNS)) ? mem_rd_data : '0;
            idx_in      = idx_ff + IW'(1);
         end
         ST_IDLE, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         scrolled_ff  <= scrolled_in;
         rsp_valid_ff <= (state_ff == ST_DONE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         char_ff <= req_char_code;
         addr_ff <= req_cell_address;
      end
      if (state_ff == ST_DONE) begin
         rsp_column_ff   <= COLUMN_W'(cursor_column);
         rsp_row_ff      <= ROW_W'(cursor_row);
         rsp_location_ff <= LOCATION_W'(cursor_location);
         rsp_scrolled_ff <= (cmd_ff == CMD_PUT) && scrolled_ff;
         rsp_cell_ff     <= (cmd_ff == CMD_READ && in_range) ? mem_rd_data : '0;
      end
   end

   assign char_code           = char_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_column   = rsp_column_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_location = rsp_location_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;
   assign rsp_cell_value      = rsp_cell_ff;

endmodule

>>> rtl/core/text_console_writer.sv
// ============================================================================
// text_console_writer
// Character-cell text console: cursor, wrap, scroll and a cell store that
// can be read back one cell at a time.
// ============================================================================
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------
//  request   start / busy           req_command, req_char_code,
//                                   req_cell_address
//  response  rsp_valid (strobe)     rsp_cursor_column, rsp_cursor_row,
//                                   rsp_cursor_location, rsp_scrolled,
//                                   rsp_cell_value
//  csr       csr_valid / csr_ready  csr_data (text attribute)
//
//  A transaction runs through execute and finish when it does not scroll;
//  a new one may start in the finish cycle. The result strobe follows in
//  the cycle after finish. A scroll adds a cell copy state between execute
//  and finish, through the single store port pair. After reset a clearing
//  pass over all COLUMNS*ROWS cells (2000 by default) holds busy high; csr
//  writes are taken at any time. The receiver cannot stall.
//
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STEP = DEF_TAB_STEP
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [CHAR_W-1:0]     req_char_code,
   input  logic [ADDR_IN_W-1:0]  req_cell_address,
   output logic                  rsp_valid,
   output logic [COLUMN_W-1:0]   rsp_cursor_column,
   output logic [ROW_W-1:0]      rsp_cursor_row,
   output logic [LOCATION_W-1:0] rsp_cursor_location,
   output logic                  rsp_scrolled,
   output logic [CELL_W-1:0]     rsp_cell_value,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [ATTR_W-1:0]     csr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int LW    = $clog2(CELLS + 1);
   localparam int AW    = $clog2(CELLS);

   logic [ATTR_W-1:0] attribute_ff;

   logic              put_step;
   logic [CHAR_W-1:0] char_code;
   cursor_status_type cursor_status;
   logic [CW-1:0]     cursor_column;
   logic [RW-1:0]     cursor_row;
   logic [LW-1:0]     cursor_location;
   logic [AW-1:0]     cursor_wr_addr;
   logic [CELL_W-1:0] cursor_wr_data;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         attribute_ff <= ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         attribute_ff <= csr_data;
      end
   end

   tcw_cursor #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STEP (TAB_STEP),
      .CELLS    (CELLS),
      .CW       (CW),
      .RW       (RW),
      .LW       (LW),
      .AW       (AW)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .step      (put_step),
      .char_code (char_code),
      .attribute (attribute_ff),
      .column    (cursor_column),
      .row       (cursor_row),
      .location  (cursor_location),
      .status    (cursor_status),
      .wr_addr   (cursor_wr_addr),
      .wr_data   (cursor_wr_data)
   );

   tcw_cell_store #(
      .CELLS (CELLS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   tcw_sequencer #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELLS   (CELLS),
      .CW      (CW),
      .RW      (RW),
      .LW      (LW),
      .AW      (AW)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_char_code       (req_char_code),
      .req_cell_address    (req_cell_address),
      .put_step            (put_step),
      .char_code           (char_code),
      .cursor_status       (cursor_status),
      .cursor_column       (cursor_column),
      .cursor_row          (cursor_row),
      .cursor_location     (cursor_location),
      .cursor_wr_addr      (cursor_wr_addr),
      .cursor_wr_data      (cursor_wr_data),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data),
      .rsp_valid           (rsp_valid),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_location (rsp_cursor_location),
      .rsp_scrolled        (rsp_scrolled),
      .rsp_cell_value      (rsp_cell_value)
   );

endmodule
